// ===== rtl/bfh_pkg.sv =====
// Package for the Bloom filter block: sizes, FNV constants, mode codes and
// the control structs passed between the sequencer, hash unit and bit store.
// No dependencies.
`default_nettype none

package bfh_pkg;

  // Filter geometry. The filter size must be a power of two.
  localparam int FILTER_BITS = 1024;
  localparam int NUM_HASHES  = 3;
  localparam int KEY_W       = 64;
  localparam int IDX_W       = $clog2(FILTER_BITS);
  localparam int ROW_W       = 32;
  localparam int COL_W       = $clog2(ROW_W);
  localparam int NUM_ROWS    = FILTER_BITS / ROW_W;
  localparam int ROW_IDX_W   = IDX_W - COL_W;
  localparam int K_W         = $clog2(NUM_HASHES + 1);

  // Byte steps for both hashes: eight for h1, then eight for h2.
  localparam int STEP_W = 4;

  // FNV-1a constants. Only the low IDX_W bits of each hash reach an index,
  // and those bits depend only on the low IDX_W bits of the operands.
  localparam logic [KEY_W-1:0] FNV_OFFSET  = 64'hcbf29ce484222325;
  localparam logic [KEY_W-1:0] FNV_PRIME   = 64'h00000100000001b3;
  localparam logic [KEY_W-1:0] SECOND_SEED = 64'h000000005bd1e995;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [ROW_W-1:0] row_t;

  // Mode codes of an input item.
  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_QUERY  = 2'd2
  } mode_t;

  // Control of the shared FNV step unit.
  typedef struct packed {
    logic init;  // start from the offset basis instead of the held hash
    logic step;  // fold one byte in this cycle
  } hash_ctl_t;

  // Request to the bit store.
  typedef struct packed {
    logic                 rd;
    logic                 wr;
    logic                 clr;
    logic [ROW_IDX_W-1:0] row;
    row_t                 wdata;
  } store_req_t;

endpackage

`default_nettype wire

// ===== rtl/bloom_filter_fnv_double_hash.sv =====
// Top level of the Bloom filter: sequencer, input and result registers.
// Depends on bfh_pkg, bfh_hash_unit and bfh_store.
//
//   Channel | Handshake          | Payload
//   --------+--------------------+-----------------
//   in      | in_valid, in_stall | mode[1:0], key[63:0]
//   out     | out_valid, out_stall | hit
//
// An insert or query first runs both hashes through the shared FNV step
// unit (one byte per cycle, two hashes), then does a read and an update on
// the bit store's single port for each of the three bits. A clear or an
// unused mode goes straight to the result. Reset empties the filter at once
// through the row valid bits. A stalled result holds in the output register
// and the sequencer waits for it before loading the next one.
`default_nettype none

module bloom_filter_fnv_double_hash (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [1:0]  mode,
  input  wire logic [63:0] key,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic        hit
);
  import bfh_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_HASH   = 5'b00010,
    S_READ   = 5'b00100,
    S_UPDATE = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [STEP_W-1:0] cnt;
  logic [K_W-1:0]    k;
  idx_t              idx;
  logic              hit_acc;
  logic              is_query;
  logic [KEY_W-1:0]  key_q;

  hash_ctl_t         hash_ctl;
  idx_t              hash;
  logic [KEY_W-1:0]  word;
  logic [2:0]        sel;
  logic [7:0]        octet;
  store_req_t        store_req;
  row_t              rd_row;
  logic              bit_set;
  logic              in_xfer;
  logic              out_free;

  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Byte selection: most significant byte first, second hash over key ^ seed.
  always_comb begin
    word  = cnt[STEP_W-1] ? (key_q ^ SECOND_SEED) : key_q;
    sel   = 3'd7 - cnt[2:0];
    octet = word[{sel, 3'b000} +: 8];
  end

  assign bit_set = rd_row[idx[COL_W-1:0]];

  // Requests to the hash unit and the bit store.
  always_comb begin
    hash_ctl.step   = (state == S_HASH);
    hash_ctl.init   = (cnt[2:0] == 3'd0);
    store_req.rd    = (state == S_READ);
    store_req.wr    = (state == S_UPDATE) && !is_query;
    store_req.clr   = in_xfer && (mode == MODE_CLEAR);
    store_req.row   = idx[IDX_W-1:COL_W];
    store_req.wdata = rd_row | (row_t'(1) << idx[COL_W-1:0]);
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_xfer) begin
          if (mode == MODE_INSERT || mode == MODE_QUERY) begin
            state_next = S_HASH;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_HASH: begin
        if (cnt == '1) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        if (k == K_W'(NUM_HASHES - 1)) begin
          state_next = S_DONE;
        end else begin
          state_next = S_READ;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Item registers, step counters and the running index.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      key_q    <= key;
      is_query <= (mode == MODE_QUERY);
      hit_acc  <= (mode == MODE_INSERT) || (mode == MODE_QUERY);
      cnt      <= '0;
    end
    if (state == S_HASH) begin
      cnt <= cnt + STEP_W'(1);
      // The held hash is h1 when the second pass begins.
      if (cnt == STEP_W'(8)) begin
        idx <= hash;
      end
      k <= '0;
    end
    if (state == S_UPDATE) begin
      if (is_query && !bit_set) begin
        hit_acc <= 1'b0;
      end
      k   <= k + K_W'(1);
      idx <= idx + hash;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      hit <= hit_acc && is_query;
    end
  end

  bfh_hash_unit u_hash (
    .clk   (clk),
    .ctl   (hash_ctl),
    .octet (octet),
    .hash  (hash)
  );

  bfh_store u_store (
    .clk    (clk),
    .rst    (rst),
    .req    (store_req),
    .rd_row (rd_row)
  );

endmodule

`default_nettype wire

// ===== rtl/bfh_hash_unit.sv =====
// Shared FNV-1a step unit: one xor and one multiply by the prime per cycle.
// Depends on bfh_pkg.
`default_nettype none

module bfh_hash_unit (
  input  wire logic              clk,
  input  wire bfh_pkg::hash_ctl_t ctl,
  input  wire logic [7:0]        octet,
  output      bfh_pkg::idx_t     hash
);
  import bfh_pkg::*;

  idx_t base;
  idx_t mixed;
  idx_t hash_next;

  // One FNV-1a round on the low index bits of the hash.
  always_comb begin
    base      = ctl.init ? FNV_OFFSET[IDX_W-1:0] : hash;
    mixed     = base ^ IDX_W'(octet);
    hash_next = IDX_W'(mixed * FNV_PRIME[IDX_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      hash <= hash_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bfh_store.sv =====
// Filter bit store: rows of bits in a memory with registered read, plus a
// valid bit per row; a clear zeroes them all at once. Depends on bfh_pkg.
`default_nettype none

module bfh_store (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire bfh_pkg::store_req_t req,
  output      bfh_pkg::row_t       rd_row
);
  import bfh_pkg::*;

  row_t                mem [NUM_ROWS];
  logic [NUM_ROWS-1:0] row_vld;
  row_t                rd_data;
  logic                rd_vld;

  // Memory port: one write or one read per cycle.
  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[req.row] <= req.wdata;
    end
    if (req.rd) begin
      rd_data <= mem[req.row];
    end
  end

  // Row valid bits; a row never written since the last clear reads as zero.
  always_ff @(posedge clk) begin
    if (rst || req.clr) begin
      row_vld <= '0;
      rd_vld  <= 1'b0;
    end else begin
      if (req.wr) begin
        row_vld[req.row] <= 1'b1;
      end
      if (req.rd) begin
        rd_vld <= row_vld[req.row];
      end
    end
  end

  assign rd_row = rd_vld ? rd_data : '0;

endmodule

`default_nettype wire

// ===== tb/bloom_filter_fnv_double_hash_checker.sv =====
// Checker for the Bloom filter block: watches both channels, predicts every
// answer from its own copy of the filter store and compares it on the result side.
// Depends on bfh_pkg for the mode codes.
`default_nettype none

module bloom_filter_fnv_double_hash_checker
  import bfh_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [1:0]  mode,
  input  wire logic [63:0] key,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic        hit,
  output int               fail_count,
  output int               pending_count,
  output int               results_checked,
  output int               query_hits
);

  // Filter geometry and FNV-1a 64-bit constants.
  localparam int          FILTER_SIZE  = 1024;
  localparam int          NUM_PROBES   = 3;
  localparam logic [63:0] OFFSET_BASIS = 64'hcbf29ce484222325;
  localparam logic [63:0] FNV64_PRIME  = 64'h00000100000001b3;
  localparam logic [63:0] KEY_SALT     = 64'h000000005bd1e995;
  localparam int          REPORT_MAX   = 10;

  typedef struct {
    logic [1:0]  mode;
    logic [63:0] key;
    logic        hit;
  } pending_answer_t;

  bit [FILTER_SIZE-1:0] filter_map;
  pending_answer_t      answers_due[$];
  int                   mismatches = 0;
  int                   checked = 0;
  int                   hits = 0;

  // FNV-1a over the eight key bytes, most significant byte first.
  function automatic logic [63:0] fnv1a_64(input logic [63:0] word);
    logic [63:0] h;
    int          i;
    h = OFFSET_BASIS;
    for (i = 0; i < 8; i++) begin
      h = h ^ {56'd0, word[63 - 8 * i -: 8]};
      h = h * FNV64_PRIME;
    end
    return h;
  endfunction

  // Double hashing: probe k lands on (h1 + k * h2) mod the filter size.
  function automatic int probe_bit(input logic [63:0] h1, input logic [63:0] h2, input int k);
    logic [63:0] sum;
    sum = h1 + 64'(k) * h2;
    return int'(sum % FILTER_SIZE);
  endfunction

  // Applies one item to the filter copy and returns the answer it should give.
  function automatic logic apply_item(input logic [1:0] op, input logic [63:0] id);
    logic [63:0] h1;
    logic [63:0] h2;
    logic        all_set;
    int          k;
    all_set = 1'b0;
    h1 = fnv1a_64(id);
    h2 = fnv1a_64(id ^ KEY_SALT);
    case (op)
      MODE_CLEAR: begin
        filter_map = '0;
      end
      MODE_INSERT: begin
        for (k = 0; k < NUM_PROBES; k++) filter_map[probe_bit(h1, h2, k)] = 1'b1;
      end
      MODE_QUERY: begin
        all_set = 1'b1;
        for (k = 0; k < NUM_PROBES; k++) begin
          if (!filter_map[probe_bit(h1, h2, k)]) all_set = 1'b0;
        end
      end
      default: begin
        // The unused mode leaves the store alone and answers zero.
      end
    endcase
    return all_set;
  endfunction

  // Results are compared before new inputs are predicted, so an answer never
  // meets an expectation queued at the same edge.
  always @(posedge clk) begin : watch
    pending_answer_t due;
    if (rst) begin
      filter_map = '0;
      answers_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (answers_due.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("[%0t] Unexpected result transfer: hit=%b with nothing pending",
                     $time, hit);
        end else begin
          due = answers_due.pop_front();
          checked++;
          if (hit !== due.hit) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("[%0t] Mismatch for mode %0d key %h: expected hit=%b, got hit=%b",
                       $time, due.mode, due.key, due.hit, hit);
          end else if (due.hit) begin
            hits++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        due.mode = mode;
        due.key  = key;
        due.hit  = apply_item(mode, key);
        answers_due.push_back(due);
      end
    end
    fail_count      <= mismatches;
    pending_count   <= answers_due.size();
    results_checked <= checked;
    query_hits      <= hits;
  end

endmodule

`default_nettype wire

// ===== tb/bloom_filter_fnv_double_hash_tb.sv =====
// Testbench top for the Bloom filter block: clock, reset, item stimulus and
// result-side stalls, with the verdict taken from the checker beside the block.
// Depends on bfh_pkg, bloom_filter_fnv_double_hash and its checker.
`default_nettype none

module bloom_filter_fnv_double_hash_tb;
  import bfh_pkg::*;

  // The fourth mode code has no meaning in the block and must be ignored.
  localparam logic [1:0] MODE_UNUSED  = 2'd3;
  localparam int         RANDOM_ITEMS = 700;
  localparam int         CYCLE_LIMIT  = 200000;
  localparam int         DRAIN_CYCLES = 40;
  localparam int         POOL_DEPTH   = 64;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  mode = MODE_CLEAR;
  logic [63:0] key = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        hit;

  int          fail_count;
  int          pending_count;
  int          results_checked;
  int          query_hits;
  int          cycle_count = 0;
  int          stall_left = 0;
  bit          no_idle = 1'b0;
  int          mode_tally[4];
  logic [63:0] inserted_keys[$];

  bloom_filter_fnv_double_hash DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .key       (key),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .hit       (hit)
  );

  bloom_filter_fnv_double_hash_checker checker_inst (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .mode            (mode),
    .key             (key),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .hit             (hit),
    .fail_count      (fail_count),
    .pending_count   (pending_count),
    .results_checked (results_checked),
    .query_hits      (query_hits)
  );

  // Free-running clock with a period of 8.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Run limit, far above the slowest legal run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results still pending",
               cycle_count, pending_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side: after each transfer, hold stall while stall_left counts down.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) stall_left = no_idle ? 0 : $urandom_range(0, 7);
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Offers one item after a random gap and returns at the edge of its transfer.
  // Valid stays high across back-to-back items, so it is never lowered and
  // raised in the same step.
  task automatic send_item(input logic [1:0] op, input logic [63:0] id);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode     <= op;
    key      <= id;
    do begin
      @(posedge clk);
    end while (in_stall);
    mode_tally[op]++;
    if (op == MODE_CLEAR) begin
      inserted_keys.delete();
    end else if (op == MODE_INSERT) begin
      inserted_keys.push_back(id);
      if (inserted_keys.size() > POOL_DEPTH) void'(inserted_keys.pop_front());
    end
  endtask

  // Random key: mostly full-width, with small, one-hot, near-all-ones keys and
  // single-bit neighbors of keys already in the filter.
  function automatic logic [63:0] pick_key();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel <= 5) return {$urandom(), $urandom()};
    else if (sel == 6) return 64'($urandom_range(0, 255));
    else if (sel == 7) return 64'd1 << $urandom_range(0, 63);
    else if (sel == 8) return ~64'($urandom_range(0, 255));
    else if (inserted_keys.size() == 0) return {$urandom(), $urandom()};
    return inserted_keys[$urandom_range(0, inserted_keys.size() - 1)]
           ^ (64'd1 << $urandom_range(0, 63));
  endfunction

  // Queries favor keys that are in the filter so that hits are common.
  function automatic logic [63:0] query_key();
    if (inserted_keys.size() != 0 && $urandom_range(0, 99) < 60)
      return inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
    return pick_key();
  endfunction

  initial begin
    int n;
    int roll;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty filter, key extremes, repeated insert, the unused mode,
    // a key equal to the salt, and clears with lookups before and after.
    send_item(MODE_QUERY,  64'd0);
    send_item(MODE_QUERY,  '1);
    send_item(MODE_INSERT, 64'd0);
    send_item(MODE_QUERY,  64'd0);
    send_item(MODE_INSERT, '1);
    send_item(MODE_QUERY,  '1);
    send_item(MODE_INSERT, '1);
    send_item(MODE_QUERY,  '1);
    send_item(MODE_UNUSED, 64'h000000005bd1e995);
    send_item(MODE_QUERY,  64'h000000005bd1e995);
    send_item(MODE_INSERT, 64'h000000005bd1e995);
    send_item(MODE_QUERY,  64'h000000005bd1e995);
    send_item(MODE_INSERT, 64'h8000000000000000);
    send_item(MODE_QUERY,  64'h0000000000000001);
    send_item(MODE_CLEAR,  64'd0);
    send_item(MODE_QUERY,  64'd0);
    send_item(MODE_QUERY,  '1);
    send_item(MODE_UNUSED, 64'd0);
    send_item(MODE_INSERT, 64'ha5a5a5a5a5a5a5a5);
    send_item(MODE_QUERY,  64'ha5a5a5a5a5a5a5a5);
    send_item(MODE_QUERY,  64'h5a5a5a5a5a5a5a5a);
    send_item(MODE_CLEAR,  '1);
    send_item(MODE_QUERY,  64'ha5a5a5a5a5a5a5a5);

    // Random: mostly inserts and queries, rare clears and unused modes, with
    // stretches where neither side idles.
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      no_idle = ((n / 100) % 3 == 1);
      roll = $urandom_range(0, 99);
      if (roll < 2) send_item(MODE_CLEAR, pick_key());
      else if (roll < 5) send_item(MODE_UNUSED, pick_key());
      else if (roll < 45) send_item(MODE_INSERT, pick_key());
      else send_item(MODE_QUERY, query_key());
    end
    in_valid <= 1'b0;
    no_idle = 1'b0;

    // Drain every expected answer, then watch a while for stray results.
    do begin
      @(posedge clk);
    end while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d clears, %0d inserts, %0d queries and %0d items of the unused mode.",
             mode_tally[MODE_CLEAR], mode_tally[MODE_INSERT], mode_tally[MODE_QUERY],
             mode_tally[MODE_UNUSED]);
    $display("Checked %0d results, %0d of them query hits; %0d mismatches.",
             results_checked, query_hits, fail_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
